[hw/rtl/mm2_pkg.sv]
`timescale 1ns / 1ps
// Shared constants and types for the streaming MurmurHash2 core.
package mm2_pkg;

    // Mixing constants of the 32-bit MurmurHash2 algorithm.
    localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
    localparam int unsigned MIX_SHIFT   = 24;
    localparam int unsigned FIN_SHIFT_A = 13;
    localparam int unsigned FIN_SHIFT_B = 15;
    localparam logic [31:0] SEED_RESET  = 32'd97;

    // Register address map of the configuration port.
    localparam logic [1:0] ADDR_SEED = 2'd0;

    // How the back end treats one queued word.
    localparam logic [1:0] MODE_FULL = 2'd0;  // full word, key mixing and fold
    localparam logic [1:0] MODE_TAIL = 2'd1;  // one to three tail bytes
    localparam logic [1:0] MODE_NONE = 2'd2;  // empty last word, finalize only

    // One classified word as it travels through the queue.
    typedef struct packed {
        logic [31:0] word;   // data word, tail bytes already masked
        logic [31:0] init;   // seed XOR total length, used on the first word
        logic        first;  // first word of a message
        logic        last;   // last word of a message
        logic [1:0]  mode;   // processing mode
    } t_item;

endpackage

[hw/rtl/mm2_front.sv]
`timescale 1ns / 1ps
// Front end: accepts input words, tracks message boundaries and classifies each word.
module mm2_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic [31:0]   i_data_word,
    input  logic [2:0]    i_byte_count,
    input  logic          i_last_word,
    input  logic [31:0]   i_total_length,
    input  logic [31:0]   i_seed,
    input  logic          i_queue_full,
    output logic          o_push,
    output mm2_pkg::t_item o_item
);
    import mm2_pkg::*;

    logic r_in_msg;
    logic n_in_msg;

    // A transfer happens whenever the queue has room.
    assign o_in_stall = i_queue_full;
    assign o_push     = i_in_valid && !i_queue_full;

    // Message tracking: a word that is not last opens or continues a message.
    always_comb begin
        n_in_msg = r_in_msg;
        if (o_push) begin
            n_in_msg = !i_last_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_msg <= 1'b0;
        end else begin
            r_in_msg <= n_in_msg;
        end
    end

    // Classification. Only a last word may carry fewer than four bytes; counts
    // above four count as a full word, and unused tail bytes are cleared here.
    always_comb begin
        o_item.init  = i_seed ^ i_total_length;
        o_item.first = !r_in_msg;
        o_item.last  = i_last_word;
        o_item.word  = i_data_word;
        o_item.mode  = MODE_FULL;
        if (i_last_word) begin
            unique case (i_byte_count)
                3'd0: begin
                    o_item.mode = MODE_NONE;
                end
                3'd1: begin
                    o_item.mode = MODE_TAIL;
                    o_item.word = i_data_word & 32'h0000_00ff;
                end
                3'd2: begin
                    o_item.mode = MODE_TAIL;
                    o_item.word = i_data_word & 32'h0000_ffff;
                end
                3'd3: begin
                    o_item.mode = MODE_TAIL;
                    o_item.word = i_data_word & 32'h00ff_ffff;
                end
                default: begin
                    o_item.mode = MODE_FULL;
                end
            endcase
        end
    end

endmodule

[hw/rtl/mm2_queue.sv]
`timescale 1ns / 1ps
// Small register queue between the front end and the hashing back end.
module mm2_queue #(
    parameter int DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mm2_pkg::t_item i_item,
    input  logic           i_pop,
    output mm2_pkg::t_item o_item,
    output logic           o_full,
    output logic           o_empty
);
    import mm2_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd_ptr];

    // Pointer and fill count update; pointers wrap at the queue depth.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push || i_pop)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("queue read while empty");
`endif

endmodule

[hw/rtl/mm2_back.sv]
`timescale 1ns / 1ps
// Back end: hashing sequencer around one shared multiplier, plus the output register.
module mm2_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  mm2_pkg::t_item i_item,
    input  logic           i_empty,
    output logic           o_pop,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output logic [31:0]    o_hash_value
);
    import mm2_pkg::*;

    // Sequencer states.
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_K1   = 3'd1;
    localparam logic [2:0] ST_K2   = 3'd2;
    localparam logic [2:0] ST_H    = 3'd3;
    localparam logic [2:0] ST_TAIL = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    logic [2:0]  r_state;
    logic [2:0]  n_state;
    logic [31:0] r_word;
    logic        r_last;
    logic [31:0] r_k;
    logic [31:0] r_h;
    logic        r_out_valid;
    logic [31:0] r_hash;
    logic [31:0] mul_a;
    logic [31:0] product;
    logic        out_free;

    assign o_pop        = (r_state == ST_IDLE) && !i_empty;
    assign out_free     = !r_out_valid || !i_out_stall;
    assign o_out_valid  = r_out_valid;
    assign o_hash_value = r_hash;

    // Operand selection for the shared multiplier; the product keeps the low 32 bits.
    always_comb begin
        unique case (r_state)
            ST_K1:   mul_a = r_word;
            ST_K2:   mul_a = r_k ^ (r_k >> MIX_SHIFT);
            ST_H:    mul_a = r_h;
            ST_TAIL: mul_a = r_h ^ r_word;
            ST_FIN:  mul_a = r_h ^ (r_h >> FIN_SHIFT_A);
            default: mul_a = '0;
        endcase
    end

    assign product = mul_a * MIX_MUL;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    unique case (i_item.mode)
                        MODE_FULL: n_state = ST_K1;
                        MODE_TAIL: n_state = ST_TAIL;
                        default:   n_state = ST_FIN;
                    endcase
                end
            end
            ST_K1:   n_state = ST_K2;
            ST_K2:   n_state = ST_H;
            ST_H:    n_state = r_last ? ST_FIN : ST_IDLE;
            ST_TAIL: n_state = ST_FIN;
            ST_FIN:  n_state = ST_OUT;
            ST_OUT:  n_state = out_free ? ST_IDLE : ST_OUT;
            default: n_state = ST_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers: the accumulator is loaded from the seed XOR total length on a first word.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    r_word <= i_item.word;
                    r_last <= i_item.last;
                    if (i_item.first) begin
                        r_h <= i_item.init;
                    end
                end
            end
            ST_K1, ST_K2: r_k <= product;
            ST_H:         r_h <= product ^ r_k;
            ST_TAIL, ST_FIN: r_h <= product;
            ST_OUT: begin
                if (out_free) begin
                    r_hash <= r_h ^ (r_h >> FIN_SHIFT_B);
                end
            end
            default: ;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_OUT))
        else $error("result presented outside the output step");

    a_fin_then_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_FIN |=> r_state == ST_OUT)
        else $error("finalization not followed by output step");
`endif

endmodule

[hw/rtl/murmur2_hash32_stream_core.sv]
`timescale 1ns / 1ps
// Top level of the streaming 32-bit MurmurHash2 core with its APB seed register.
// The core hashes a message delivered as little-endian 32-bit words and presents one
// hash per message once its last word has been transferred. Every multiplication by the
// mixing constant runs through one shared 32x32 multiplier, one per cycle, and that sets
// the rate: a full word occupies the back end for the key steps K1 and K2 and the fold
// step H, a tail of one to three bytes for the TAIL step, and the last word of a message
// adds finalization and output steps. A queue of QUEUE_DEPTH words lets the input keep
// transferring while the back end works or the result waits, until the queue fills.
// The seed register (address 0) resets to 97 and is sampled on each message's first word.
module murmur2_hash32_stream_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_data_word,
    input  logic [2:0]  i_byte_count,
    input  logic        i_last_word,
    input  logic [31:0] i_total_length,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_hash_value,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mm2_pkg::*;

    logic [31:0] r_seed;
    logic        push;
    logic        pop;
    logic        q_full;
    logic        q_empty;
    t_item       push_item;
    t_item       head_item;

    // Configuration port: zero wait states, one seed register.
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_SEED) ? r_seed : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= SEED_RESET;
        end else if (psel && penable && pwrite && paddr == ADDR_SEED) begin
            r_seed <= pwdata;
        end
    end

    mm2_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_data_word    (i_data_word),
        .i_byte_count   (i_byte_count),
        .i_last_word    (i_last_word),
        .i_total_length (i_total_length),
        .i_seed         (r_seed),
        .i_queue_full   (q_full),
        .o_push         (push),
        .o_item         (push_item)
    );

    mm2_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_item  (head_item),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    mm2_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (head_item),
        .i_empty      (q_empty),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_hash_value (o_hash_value)
    );

endmodule

[bench/murmur2_checker.sv]
`timescale 1ns / 1ps
// Checker for the MurmurHash2 core: predicts each message hash and compares output transfers.
module murmur2_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [31:0] i_data_word,
    input  logic [2:0]  i_byte_count,
    input  logic        i_last_word,
    input  logic [31:0] i_total_length,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [31:0] i_hash_value,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [1:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output int          o_errors,
    output int          o_pending
);
    import mm2_pkg::*;

    logic [31:0] seed_shadow;
    logic [31:0] running_hash;
    logic        mid_message;
    logic [31:0] hash_queue[$];
    int          mismatch_count = 0;

    // Scramble one full key word and fold it into the running hash.
    function automatic logic [31:0] absorb_word(input logic [31:0] h, input logic [31:0] k);
        logic [31:0] m;
        m = k * MIX_MUL;
        m = m ^ (m >> MIX_SHIFT);
        m = m * MIX_MUL;
        return (h * MIX_MUL) ^ m;
    endfunction

    always @(posedge i_clk) begin : predict_and_check
        logic [31:0] h;
        logic [31:0] want;
        if (!i_rst_n) begin
            seed_shadow  = SEED_RESET;
            running_hash = '0;
            mid_message  = 1'b0;
            hash_queue.delete();
        end else begin
            // A completed seed write applies from the next message on.
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == ADDR_SEED) begin
                seed_shadow = i_pwdata;
            end

            // Each input transfer advances the hash; a last word yields one result.
            if (i_in_valid && !i_in_stall) begin
                h = mid_message ? running_hash : (seed_shadow ^ i_total_length);
                if (!i_last_word) begin
                    // Words before the last one are always full, whatever their count.
                    running_hash = absorb_word(h, i_data_word);
                    mid_message  = 1'b1;
                end else begin
                    // Counts above four saturate to a full word.
                    if (i_byte_count >= 3'd4) begin
                        h = absorb_word(h, i_data_word);
                    end else if (i_byte_count != 3'd0) begin
                        if (i_byte_count == 3'd3) begin
                            h = h ^ (i_data_word & 32'h00ff_0000);
                        end
                        if (i_byte_count >= 3'd2) begin
                            h = h ^ (i_data_word & 32'h0000_ff00);
                        end
                        h = h ^ (i_data_word & 32'h0000_00ff);
                        h = h * MIX_MUL;
                    end
                    // Final avalanche.
                    h = h ^ (h >> FIN_SHIFT_A);
                    h = h * MIX_MUL;
                    h = h ^ (h >> FIN_SHIFT_B);
                    running_hash = h;
                    mid_message  = 1'b0;
                    hash_queue   = {hash_queue, h};
                end
            end

            // Each output transfer must match the oldest outstanding hash.
            if (i_out_valid && !i_out_stall) begin
                if (hash_queue.size() == 0) begin
                    $error("hash_value: unexpected transfer, expected none, actual %08h",
                           i_hash_value);
                    mismatch_count++;
                end else begin
                    want = hash_queue.pop_front();
                    if (i_hash_value !== want) begin
                        $error("hash_value: expected %08h, actual %08h", want, i_hash_value);
                        mismatch_count++;
                    end
                end
            end
        end
        o_errors  <= mismatch_count;
        o_pending <= hash_queue.size();
    end

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// Top of the MurmurHash2 core bench: clock, reset, stimulus, seed writes and the verdict.
module testbench;
    import mm2_pkg::*;

    localparam int         SETTLE_CYCLES = 24;
    localparam int         LONG_HOLD     = 120;
    localparam int         PHASE_ITEMS   = 125;
    localparam int         CYCLE_LIMIT   = 300000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [31:0] i_data_word;
    logic [2:0]  i_byte_count;
    logic        i_last_word;
    logic [31:0] i_total_length;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [31:0] o_hash_value;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int check_errors;
    int check_pending;

    // Knobs shared between the sender and the receiver processes.
    int in_gap_pct    = 0;
    int out_stall_pct = 0;
    bit hold_req      = 1'b0;
    int items_sent    = 0;

    murmur2_hash32_stream_core u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_data_word    (i_data_word),
        .i_byte_count   (i_byte_count),
        .i_last_word    (i_last_word),
        .i_total_length (i_total_length),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_hash_value   (o_hash_value),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    murmur2_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_data_word    (i_data_word),
        .i_byte_count   (i_byte_count),
        .i_last_word    (i_last_word),
        .i_total_length (i_total_length),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_hash_value   (o_hash_value),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_pready       (pready),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .o_errors       (check_errors),
        .o_pending      (check_pending)
    );

    // 2 ns clock.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Output side: short random stalls, plus one long hold-off on request.
    initial begin : sink_side
        int n;
        bit hold_done;
        hold_done = 1'b0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else if ($urandom_range(0, 99) < out_stall_pct) begin
                n = $urandom_range(1, 5);
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // Run limit.
    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    // Offer one word and hold it until the transfer; then maybe leave a gap.
    task automatic send_item(input logic [31:0] word, input logic [2:0] count,
                             input logic last, input logic [31:0] len);
        int n;
        i_in_valid     <= 1'b1;
        i_data_word    <= word;
        i_byte_count   <= count;
        i_last_word    <= last;
        i_total_length <= len;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
        if ($urandom_range(0, 99) < in_gap_pct) begin
            n = $urandom_range(1, 5);
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // A message of random words; mostly well formed, sometimes with odd counts or length.
    task automatic send_random_message();
        int          n_words;
        logic [2:0]  tail;
        logic [2:0]  count;
        logic [31:0] len;
        n_words = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
        tail = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7))
                                            : 3'($urandom_range(0, 4));
        len = 32'((n_words - 1) * 4 + ((tail > 3'd4) ? 4 : int'(tail)));
        if ($urandom_range(0, 7) == 0) begin
            len = $urandom();
        end
        for (int i = 0; i < n_words; i++) begin
            if (i == n_words - 1) begin
                send_item($urandom(), tail, 1'b1, len);
            end else begin
                count = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7)) : 3'd4;
                send_item($urandom(), count, 1'b0, len);
            end
        end
    endtask

    // Drop valid and wait until every hash is out and the core has drained.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (check_pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register write: setup cycle, then access cycle until pready.
    task automatic apb_write(input logic [1:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Main sequence.
    initial begin : stimulus
        logic [31:0] phase_seed[4];
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_data_word    <= '0;
        i_byte_count   <= '0;
        i_last_word    <= 1'b0;
        i_total_length <= '0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed messages under the reset seed.
        in_gap_pct    = 20;
        out_stall_pct = 20;
        send_item(32'h0000_0000, 3'd0, 1'b1, 32'd0);             // empty message
        send_item(32'hffff_ffa5, 3'd1, 1'b1, 32'd1);             // one byte, junk above
        send_item(32'hdead_beef, 3'd2, 1'b1, 32'd2);
        send_item(32'hffff_ffff, 3'd3, 1'b1, 32'd3);
        send_item(32'hffff_ffff, 3'd4, 1'b1, 32'd4);
        send_item(32'h0000_0000, 3'd4, 1'b1, 32'hffff_ffff);
        send_item(32'h1234_5678, 3'd5, 1'b1, 32'd4);             // counts above four
        send_item(32'h8765_4321, 3'd6, 1'b1, 32'd4);
        send_item(32'ha5a5_5a5a, 3'd7, 1'b1, 32'd4);
        // Middle words with odd counts still count as full words.
        send_item(32'hffff_ffff, 3'd0, 1'b0, 32'hffff_ffff);
        send_item(32'h8000_0001, 3'd7, 1'b0, 32'hffff_ffff);
        send_item(32'h1357_9bdf, 3'd0, 1'b1, 32'hffff_ffff);
        // Well-formed seven-byte message.
        send_item(32'h0403_0201, 3'd4, 1'b0, 32'd7);
        send_item(32'hff07_0605, 3'd3, 1'b1, 32'd7);
        // Length field that does not match the words sent.
        send_item(32'h0bad_f00d, 3'd4, 1'b0, 32'd1);
        send_item(32'hcafe_babe, 3'd4, 1'b0, 32'd1);
        send_item(32'h0000_00ff, 3'd1, 1'b1, 32'd1);
        drain();

        // Random phases, each under its own seed.
        phase_seed[0] = 32'h0000_0000;
        phase_seed[1] = 32'hffff_ffff;
        phase_seed[2] = $urandom();
        phase_seed[3] = $urandom();
        for (int p = 0; p < 4; p++) begin
            apb_write(ADDR_SEED, phase_seed[p]);
            unique case (p)
                0: begin
                    in_gap_pct    = 25;
                    out_stall_pct = 25;
                end
                1: begin
                    // Back pressure: a long output hold while the input keeps offering.
                    in_gap_pct    = 0;
                    out_stall_pct = 15;
                    hold_req      = 1'b1;
                end
                2: begin
                    in_gap_pct    = 40;
                    out_stall_pct = 40;
                end
                default: begin
                    // Closing stretch runs flat out.
                    in_gap_pct    = 0;
                    out_stall_pct = 0;
                end
            endcase
            items_sent = 0;
            while (items_sent < PHASE_ITEMS) begin
                send_random_message();
            end
            drain();
        end

        if (check_errors == 0 && check_pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/mm2_pkg.sv
hw/rtl/mm2_front.sv
hw/rtl/mm2_queue.sv
hw/rtl/mm2_back.sv
hw/rtl/murmur2_hash32_stream_core.sv
bench/murmur2_checker.sv
bench/testbench.sv
